// ===== sv/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sm3_pkg.sv =====
package sm3_pkg;

    typedef logic [31:0] t_word;

    localparam t_word T_LOW  = 32'h79cc4519;
    localparam t_word T_HIGH = 32'h7a879d8a;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam t_word IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef struct packed {
        logic  start;
        logic  done;
        logic  busy;
    } t_rnd_ctl;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== sv/sm3_stream_if.sv =====
interface sm3_stream_if #(
    parameter int W = 36
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sm3_round.sv =====
// one compression round per cycle, rolling 16-word expansion window
module sm3_round (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  sm3_pkg::t_word          i_blk [16],
    input  sm3_pkg::t_word          i_cv [8],
    output sm3_pkg::t_word          o_cv [8],
    output logic                    o_done,
    output logic                    o_busy
);
    sm3_pkg::t_word r_w [16];
    sm3_pkg::t_word r_v [8];
    logic [6:0]     r_cnt;
    logic           r_busy;
    logic           r_done;

    sm3_pkg::t_word a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
    logic           lo;

    always_comb begin
        lo  = (r_cnt < 7'd16);
        tj  = sm3_pkg::rotl(lo ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, r_cnt[4:0]);
        a12 = sm3_pkg::rotl(r_v[0], 5'd12);
        ss1 = sm3_pkg::rotl(a12 + r_v[4] + tj, 5'd7);
        ss2 = ss1 ^ a12;
        if (lo) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = ff + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_v[7] + ss1 + r_w[0];
        wn  = sm3_pkg::perm1(r_w[0] ^ r_w[7] ^ sm3_pkg::rotl(r_w[13], 5'd15))
              ^ sm3_pkg::rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_w    <= i_blk;
            r_v    <= i_cv;
        end else if (r_busy) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= wn;
            r_v[0] <= tt1;
            r_v[1] <= r_v[0];
            r_v[2] <= sm3_pkg::rotl(r_v[1], 5'd9);
            r_v[3] <= r_v[2];
            r_v[4] <= sm3_pkg::perm0(tt2);
            r_v[5] <= r_v[4];
            r_v[6] <= sm3_pkg::rotl(r_v[5], 5'd19);
            r_v[7] <= r_v[6];
            r_cnt  <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_comb for (int k = 0; k < 8; k++) o_cv[k] = r_v[k] ^ i_cv[k];
    assign o_done = r_done;
    assign o_busy = r_busy;

`include "assert_macros.svh"
    `ASSERT_IMPL(a_cnt_idle, i_clk, i_rst_n, !r_busy, r_cnt == 7'd0 || r_cnt == 7'd64)
    `ASSERT_NEXT(a_done_end, i_clk, i_rst_n, r_busy && r_cnt == 7'd63, r_done && !r_busy)
    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, r_done, !r_busy)
endmodule

// ===== sv/sm3_hash_core.sv =====
// SM3 hash engine. Input items carry up to four message bytes (first byte in
// item bits 35..28) with a byte count; the item marked last pads the
// message and yields eight digest items, word 0 first. Each item passes
// through these steps: accept, a merge step for each valid byte, and a
// final check. Every completed 64-byte block is compressed in the shared
// round unit (one round per cycle over 64 rounds plus load and fold). A
// last item adds a padding step, a length step, one or two such blocks
// and eight output items, delivered as the receiver takes them. The engine
// takes no new item while a block compresses or the digest is delivered.
module sm3_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sm3_stream_if.sink   in_if,
    sm3_stream_if.source out_if
);
    typedef enum logic [2:0] {S_IDLE, S_BYTE, S_CMP, S_WAIT, S_LEN, S_OUT} t_state;

    t_state          r_st;
    sm3_pkg::t_word  r_blk [16];
    sm3_pkg::t_word  r_cv [8];
    logic [5:0]      r_fill;
    logic [63:0]     r_len;
    sm3_pkg::t_word  r_word;
    logic [2:0]      r_cnt;
    logic            r_last;
    logic            r_pad;
    logic            r_fin;
    logic [2:0]      r_oi;
    logic            r_start;

    sm3_pkg::t_word  cv_new [8];
    logic            rdone, rbusy;
    logic [2:0]      cnt_in;
    logic [7:0]      byte_v;

    sm3_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_blk(r_blk),
        .i_cv(r_cv), .o_cv(cv_new), .o_done(rdone), .o_busy(rbusy)
    );

    assign cnt_in = (in_if.data[3:1] > 3'd4) ? 3'd4 : in_if.data[3:1];
    assign byte_v = r_word[31:24];
    assign in_if.ready  = (r_st == S_IDLE);
    assign out_if.valid = (r_st == S_OUT);
    assign out_if.data  = {r_cv[r_oi], r_oi, r_oi == 3'd7};

    always_ff @(posedge i_clk) begin
        r_start <= 1'b0;
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_cv   <= sm3_pkg::IV;
            r_fill <= '0;
            r_len  <= '0;
            r_oi   <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: if (in_if.valid) begin
                    r_word <= in_if.data[35:4];
                    r_cnt  <= cnt_in;
                    r_last <= in_if.data[0];
                    r_pad  <= 1'b0;
                    r_len  <= r_len + {58'd0, cnt_in, 3'd0};
                    r_st   <= S_BYTE;
                end
                S_BYTE: begin
                    if (r_cnt != 3'd0 || (r_last && !r_pad)) begin
                        for (int b = 0; b < 4; b++)
                            if (r_fill[1:0] == 2'(b)) begin
                                r_blk[r_fill[5:2]][31-8*b -: 8] <=
                                    (r_cnt != 3'd0) ? byte_v : sm3_pkg::PAD_BYTE;
                                for (int z = b + 1; z < 4; z++)
                                    if (r_cnt == 3'd0) r_blk[r_fill[5:2]][31-8*z -: 8] <= 8'h00;
                            end
                        if (r_cnt != 3'd0) begin
                            r_word <= r_word << 8;
                            r_cnt  <= r_cnt - 3'd1;
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_start <= 1'b1;
                                r_fin   <= 1'b0;
                                r_st    <= S_CMP;
                            end
                        end else begin
                            r_pad <= 1'b1;
                            for (int q = 0; q < 16; q++)
                                if (4'(q) > r_fill[5:2]) r_blk[q] <= '0;
                            if (r_fill >= 6'd56) begin
                                r_start <= 1'b1;
                                r_fin   <= 1'b0;
                                r_st    <= S_CMP;
                            end else r_st <= S_LEN;
                        end
                    end else if (r_last) r_st <= S_LEN;
                    else r_st <= S_IDLE;
                end
                S_CMP: r_st <= S_WAIT;
                S_WAIT: if (rdone) begin
                    r_cv <= cv_new;
                    if (r_fin) begin
                        r_oi <= '0;
                        r_st <= S_OUT;
                    end else if (r_pad) begin
                        for (int q = 0; q < 16; q++) r_blk[q] <= '0;
                        r_st <= S_LEN;
                    end else r_st <= S_BYTE;
                end
                S_LEN: begin
                    r_blk[14] <= r_len[63:32];
                    r_blk[15] <= r_len[31:0];
                    r_start   <= 1'b1;
                    r_fin     <= 1'b1;
                    r_st      <= S_CMP;
                end
                S_OUT: if (out_if.ready) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        r_cv   <= sm3_pkg::IV;
                        r_fill <= '0;
                        r_len  <= '0;
                        r_st   <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_out_idle_round, i_clk, i_rst_n, out_if.valid, !rbusy)
    `ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, rbusy, !in_if.ready)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, r_start, rbusy)
endmodule
